// ===== rtl/nearest_time_coincidence_builder_macros.svh =====
// assertion helpers shared by the rtl
`ifndef NEAREST_TIME_COINCIDENCE_BUILDER_MACROS_SVH
`define NEAREST_TIME_COINCIDENCE_BUILDER_MACROS_SVH

// checked on every clock edge outside reset
`define NTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define NTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// Types and constants of the nearest-time coincidence builder.
// ----------------------------------------------------------------------------
package nts_pkg;

  localparam int unsigned HIT_DEPTH = 4096;
  localparam int unsigned IDX_W     = $clog2(HIT_DEPTH);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned EN_W      = 14;
  localparam int unsigned WORD_W    = TIME_W + EN_W;
  localparam int unsigned ADDR_W    = IDX_W + 1;

  localparam logic [7:0]      WINDOW_RESET = 8'd10;
  localparam logic [EN_W-1:0] SAT_RESET    = 14'd16383;

  typedef enum logic [1:0] {
    MODE_LOAD1 = 2'd0,
    MODE_LOAD2 = 2'd1,
    MODE_MATCH = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_USE_THIRD = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_SAT       = 2'd2,
    REG_NONE      = 2'd3
  } reg_e;

  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] hit_time;
    logic [EN_W-1:0]   hit_energy;
    logic [TIME_W-1:0] prev_time;
    logic [TIME_W-1:0] next_time;
    logic              has_prev;
    logic              has_next;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ch0;
    logic [EN_W-1:0]   energy_ch0;
    logic [TIME_W-1:0] time_ch1;
    logic [EN_W-1:0]   energy_ch1;
    logic [TIME_W-1:0] time_ch2;
    logic [EN_W-1:0]   energy_ch2;
  } out_t;

  typedef struct packed {
    logic              start;
    logic              ch;
    logic [IDX_W-1:0]  start_idx;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] t0;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } scan_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              found;
    logic [IDX_W-1:0]  best_idx;
    logic [WORD_W-1:0] best_word;
  } scan_rsp_t;

endpackage

// ===== rtl/nts_if.sv =====
// ----------------------------------------------------------------------------
// nts_in_if / nts_out_if
// Valid/ready channels carrying hit items and coincidence events.
// ----------------------------------------------------------------------------
interface nts_in_if;
  import nts_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nts_out_if;
  import nts_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nts_scan.sv =====
// ----------------------------------------------------------------------------
// nts_scan
// Hit store of both channels and the shared nearest-time search unit.
// ----------------------------------------------------------------------------
module nts_scan import nts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_req_t req_i,
  output scan_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_P0   = 4'b0010,
    S_P1   = 4'b0100,
    S_RUN  = 4'b1000
  } scan_state_e;

  scan_state_e state_q, state_d;

  logic [WORD_W-1:0] mem_q [2*HIT_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic [ADDR_W-1:0] rd_addr;

  logic              ch_q, ch_d;
  logic [CNT_W-1:0]  i_q, i_d, cnt_q, cnt_d;
  logic [TIME_W-1:0] t0_q, t0_d, prev_q, prev_d, best_dt_q, best_dt_d;
  logic [WORD_W-1:0] cur_q, cur_d, best_w_q, best_w_d;
  logic [IDX_W-1:0]  best_i_q, best_i_d;
  logic              found_q, found_d, done_q, done_d;

  logic [CNT_W-1:0]  i_inc;
  logic [TIME_W-1:0] t_cur, t_next, dt;
  logic              skip, brk;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // read runs two entries ahead of the one being judged
  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = {req_i.ch, req_i.start_idx - IDX_W'(1)};
      S_P0:    rd_addr = {ch_q, i_q[IDX_W-1:0]};
      S_P1:    rd_addr = {ch_q, i_q[IDX_W-1:0] + IDX_W'(1)};
      S_RUN:   rd_addr = {ch_q, i_q[IDX_W-1:0] + IDX_W'(2)};
      default: rd_addr = {ch_q, i_q[IDX_W-1:0]};
    endcase
  end

  assign t_cur  = cur_q[TIME_W-1:0];
  assign t_next = rdata_q[TIME_W-1:0];
  assign i_inc  = i_q + CNT_W'(1);
  assign skip   = (i_q != '0) && ((i_inc >= cnt_q) || (t_cur < prev_q) || (t_cur > t_next));
  assign dt     = (t_cur > t0_q) ? (t_cur - t0_q) : (t0_q - t_cur);
  assign brk    = !skip && found_q && (dt > best_dt_q);

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    i_d       = i_q;
    cnt_d     = cnt_q;
    t0_d      = t0_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    best_dt_d = best_dt_q;
    best_w_d  = best_w_q;
    best_i_d  = best_i_q;
    found_d   = found_q;
    done_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          ch_d    = req_i.ch;
          i_d     = {1'b0, req_i.start_idx};
          cnt_d   = req_i.cnt;
          t0_d    = req_i.t0;
          found_d = 1'b0;
          if ({1'b0, req_i.start_idx} >= req_i.cnt) begin
            done_d = 1'b1;
          end else begin
            state_d = S_P0;
          end
        end
      end
      S_P0: begin
        prev_d  = rdata_q[TIME_W-1:0];
        state_d = S_P1;
      end
      S_P1: begin
        cur_d   = rdata_q;
        state_d = S_RUN;
      end
      S_RUN: begin
        if (brk) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          if (!skip) begin
            found_d   = 1'b1;
            best_dt_d = dt;
            best_w_d  = cur_q;
            best_i_d  = i_q[IDX_W-1:0];
          end
          prev_d = t_cur;
          cur_d  = rdata_q;
          i_d    = i_inc;
          if (i_inc >= cnt_q) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    i_q       <= i_d;
    cnt_q     <= cnt_d;
    t0_q      <= t0_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    best_dt_q <= best_dt_d;
    best_w_q  <= best_w_d;
    best_i_q  <= best_i_d;
  end

  assign rsp_o.busy      = (state_q != S_IDLE);
  assign rsp_o.done      = done_q;
  assign rsp_o.found     = found_q;
  assign rsp_o.best_idx  = best_i_q;
  assign rsp_o.best_word = best_w_q;

endmodule

// ===== rtl/nearest_time_coincidence_builder.sv =====
// ----------------------------------------------------------------------------
// nearest_time_coincidence_builder
// Matches channel-0 hits to nearest-time stored hits of ch. 1 (and 2 if enabled).
// ----------------------------------------------------------------------------
// channel   dir   handshake        carries
// in_i      in    valid/ready      mode, hit and neighbour times
// out_o     out   valid/ready      coincidence event (three hits)
// apb       in    psel/penable     use_third_channel, window_back, saturation_code
//
// loads and clears complete in the idle state; a match runs a search of channel 1
// and, when enabled, one of channel 2, the search unit walking its entries one
// per cycle; a search with nothing to walk ends without leaving its idle state.
// a finished event waits in the output register while the next transaction
// is taken. reset clears counts, search starts and the done flag; the
// store itself holds no reset value and its data is used only below the counts.
`include "nearest_time_coincidence_builder_macros.svh"

module nearest_time_coincidence_builder import nts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nts_in_if.sink      in_i,
  nts_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_SCAN1 = 5'b00010,
    T_SCAN2 = 5'b00100,
    T_CHECK = 5'b01000,
    T_HOLD  = 5'b10000
  } top_state_e;

  top_state_e state_q, state_d;

  logic            third_q;
  logic [7:0]      window_q;
  logic [EN_W-1:0] sat_q;
  reg_e            reg_sel;
  logic            cfg_wr;

  logic [CNT_W-1:0]  c1_q, c1_d, c2_q, c2_d;
  logic [IDX_W-1:0]  s1_q, s1_d, s2_q, s2_d, b1_q, b1_d, b2_q, b2_d, nstart;
  logic              done_q, done_d, ok1_q, ok1_d, ok2_q, ok2_d;
  logic [TIME_W-1:0] t0_q, t0_d;
  logic [EN_W-1:0]   e0_q, e0_d;
  logic [WORD_W-1:0] w1_q, w1_d, w2_q, w2_d;
  logic              ov_q, ov_d;
  out_t              out_q, out_d;

  scan_req_t req;
  scan_rsp_t rsp;

  logic in_acc, order_bad, sat_hit, out_load;
  in_t  in_d;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      REG_USE_THIRD: prdata = {31'd0, third_q};
      REG_WINDOW:    prdata = {24'd0, window_q};
      REG_SAT:       prdata = {{(32-EN_W){1'b0}}, sat_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      third_q  <= 1'b0;
      window_q <= WINDOW_RESET;
      sat_q    <= SAT_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_USE_THIRD: third_q  <= pwdata[0];
        REG_WINDOW:    window_q <= pwdata[7:0];
        REG_SAT:       sat_q    <= pwdata[EN_W-1:0];
        default:       ;
      endcase
    end
  end

  assign in_d      = in_i.data;
  assign in_i.ready = (state_q == T_IDLE);
  assign in_acc    = in_i.valid && in_i.ready;
  assign order_bad = in_d.has_prev && (!in_d.has_next || (in_d.hit_time < in_d.prev_time) ||
                     (in_d.hit_time > in_d.next_time));

  assign nstart = (rsp.best_idx >= IDX_W'(window_q)) ? (rsp.best_idx - IDX_W'(window_q)) : '0;

  assign sat_hit = (w1_q[WORD_W-1:TIME_W] == sat_q) || (e0_q == sat_q) ||
                   (third_q && (w2_q[WORD_W-1:TIME_W] == sat_q));
  assign out_load = (state_q == T_CHECK) && ok1_q && ok2_q && !sat_hit &&
                    (!ov_q || out_o.ready);

  always_comb begin
    req           = '0;
    req.wr_data   = {in_d.hit_energy, in_d.hit_time};
    req.wr_addr   = {1'b0, c1_q[IDX_W-1:0]};
    req.start_idx = s1_q;
    req.cnt       = c1_q;
    req.t0        = in_d.hit_time;
    case (state_q)
      T_IDLE: begin
        if (in_acc && (in_d.mode == MODE_LOAD1)) begin
          req.wr_en = (c1_q < CNT_W'(HIT_DEPTH));
        end
        if (in_acc && (in_d.mode == MODE_LOAD2)) begin
          req.wr_en   = (c2_q < CNT_W'(HIT_DEPTH));
          req.wr_addr = {1'b1, c2_q[IDX_W-1:0]};
        end
        req.start = in_acc && (in_d.mode == MODE_MATCH) && !done_q && !order_bad;
      end
      T_SCAN1: begin
        req.start     = rsp.done && third_q;
        req.ch        = 1'b1;
        req.start_idx = s2_q;
        req.cnt       = c2_q;
        req.t0        = t0_q;
      end
      default: ;
    endcase
  end

  nts_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_comb begin
    state_d = state_q;
    c1_d = c1_q;  c2_d = c2_q;  s1_d = s1_q;  s2_d = s2_q;
    b1_d = b1_q;  b2_d = b2_q;  w1_d = w1_q;  w2_d = w2_q;
    ok1_d = ok1_q;  ok2_d = ok2_q;  done_d = done_q;
    t0_d = t0_q;  e0_d = e0_q;
    ov_d  = ov_q && !out_o.ready;
    out_d = out_q;
    case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          case (in_d.mode)
            MODE_LOAD1: if (req.wr_en) c1_d = c1_q + CNT_W'(1);
            MODE_LOAD2: if (req.wr_en) c2_d = c2_q + CNT_W'(1);
            MODE_CLEAR: begin
              c1_d = '0;  c2_d = '0;  s1_d = '0;  s2_d = '0;  done_d = 1'b0;
            end
            MODE_MATCH: begin
              t0_d = in_d.hit_time;
              e0_d = in_d.hit_energy;
              if (req.start) state_d = T_SCAN1;
            end
            default: ;
          endcase
        end
      end
      T_SCAN1: begin
        if (rsp.done) begin
          ok1_d = rsp.found;
          ok2_d = 1'b1;
          b1_d  = rsp.best_idx;
          w1_d  = rsp.best_word;
          w2_d  = '0;
          b2_d  = '0;
          if (rsp.found) s1_d = nstart;
          state_d = third_q ? T_SCAN2 : T_CHECK;
        end
      end
      T_SCAN2: begin
        if (rsp.done) begin
          ok2_d = rsp.found;
          b2_d  = rsp.best_idx;
          w2_d  = rsp.best_word;
          if (rsp.found) s2_d = nstart;
          state_d = T_CHECK;
        end
      end
      T_CHECK: begin
        if (!ok1_q || !ok2_q || sat_hit) begin
          state_d = T_IDLE;
        end else if (out_load) begin
          ov_d  = 1'b1;
          out_d = '{time_ch0: t0_q, energy_ch0: e0_q,
                    time_ch1: w1_q[TIME_W-1:0], energy_ch1: w1_q[WORD_W-1:TIME_W],
                    time_ch2: w2_q[TIME_W-1:0], energy_ch2: w2_q[WORD_W-1:TIME_W]};
          // end of matching once a second-last stored hit is used
          if ((c1_q >= CNT_W'(2)) && ({1'b0, b1_q} == c1_q - CNT_W'(2))) done_d = 1'b1;
          if (third_q && (c2_q >= CNT_W'(2)) && ({1'b0, b2_q} == c2_q - CNT_W'(2))) begin
            done_d = 1'b1;
          end
          state_d = T_IDLE;
        end else begin
          state_d = T_HOLD;
        end
      end
      T_HOLD: state_d = T_CHECK;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      c1_q    <= '0;
      c2_q    <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
      done_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      done_q  <= done_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_q  <= b1_d;
    b2_q  <= b2_d;
    w1_q  <= w1_d;
    w2_q  <= w2_d;
    ok1_q <= ok1_d;
    ok2_q <= ok2_d;
    t0_q  <= t0_d;
    e0_q  <= e0_d;
    out_q <= out_d;
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  `NTS_ASSERT(a_scan_start_idle, req.start |-> !rsp.busy, "search started while busy")
  `NTS_ASSERT(a_load_needs_match, out_load |-> (ok1_q && ok2_q), "event without both matches")
  `NTS_ASSERT(a_no_match_after_done, (state_q == T_SCAN1) |-> !done_q, "search after end of matching")
  `NTS_ASSERT_ALWAYS(a_count_bound, (c1_q <= CNT_W'(HIT_DEPTH)) && (c2_q <= CNT_W'(HIT_DEPTH)),
    "hit count beyond store depth")

endmodule
